// ===== hw/rtl/ffa_pkg.sv =====
// Package for the first-fit block allocator: sizes, block marks, sequencer states
// and the command and result beat types.
// Has no dependencies; first_fit_block_allocator imports it.
package ffa_pkg;

  // Map size and the widths that follow from it.
  localparam int MaxBlocks = 1024;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int MarkW     = 2;

  // Operation codes carried in the func field.
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Per-block marks held in the map.
  typedef enum logic [MarkW-1:0] {
    MARK_FREE = 2'd0,
    MARK_USED = 2'd1,
    MARK_HEAD = 2'd2
  } mark_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASCAN,
    ST_AMARK,
    ST_FWALK,
    ST_RESP
  } state_e;

  // Command beat.
  typedef struct packed {
    logic            func;
    logic [CntW-1:0] request_blocks;
    logic [IdxW-1:0] release_index;
  } ffa_req_t;

  // Result beat.
  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] block_index;
    logic [CntW-1:0] used_blocks;
    logic [CntW-1:0] free_blocks;
  } ffa_res_t;

endpackage

// ===== hw/rtl/ffa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies.
module ffa_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit contiguous block allocator: sequencer, counters and the block map.
// Depends on ffa_pkg and ffa_ram.
//
// Usage: a command beat (req_i) is taken at a clock edge where start is high and
// busy is low. func selects allocate (a first-fit search for request_blocks free
// blocks in a row) or free (clear the run whose head is release_index). Each
// command gives exactly one result beat on result_o, marked by result_valid_o
// for a single cycle; the receiver cannot stall and must take it then.
// A rejected command (zero or oversized request, free beyond the limit) goes
// straight to the result state. An allocate walks the map one block per cycle
// through the map RAM read port, then writes the run one block per cycle.
// A free walks its run one block per cycle.
// busy stays high for the whole command; one command is in flight at a time.
// The user must write num_blocks through cfg_we_i / cfg_wdata_i only while
// the block is idle; the block itself does not enforce this. Reset: the map RAM
// is cleared by a pass over all MaxBlocks (1024) entries with busy high;
// configuration writes are taken during that pass.
module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ffa_req_t        req_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output ffa_res_t        result_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] num_blocks_q, num_blocks_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] run_q, run_d;
  logic [CntW-1:0] req_q, req_d;
  logic [IdxW-1:0] eidx_q, eidx_d;
  logic [IdxW-1:0] wptr_q, wptr_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] end_q, end_d;
  logic            pend_q, pend_d;
  logic            first_q, first_d;
  logic            ok_q, ok_d;
  logic            out_valid_q, out_valid_d;
  ffa_res_t        res_q, res_d;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [MarkW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [MarkW-1:0] ram_rdata;

  logic [CntW-1:0] lim;
  logic [CntW:0]   need;
  logic            issue;
  logic [CntW-1:0] run_inc;

  // Block map storage.
  ffa_ram #(
    .Width(MarkW),
    .Depth(MaxBlocks)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Effective block limit, and the count check made before a search.
  assign lim     = (num_blocks_q > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : num_blocks_q;
  assign need    = {1'b0, req_i.request_blocks} + {1'b0, used_q};
  assign issue   = cnt_q < lim;
  assign run_inc = run_q + CntW'(1);

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_o       = res_q;

  // Configuration register.
  assign num_blocks_d = cfg_we_i ? cfg_wdata_i : num_blocks_q;

  // Sequencer: next state, map accesses and counters.
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    req_d       = req_q;
    eidx_d      = eidx_q;
    wptr_d      = wptr_q;
    head_d      = head_q;
    end_d       = end_q;
    pend_d      = pend_q;
    first_d     = first_q;
    ok_d        = ok_q;
    out_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = wptr_q;
    ram_wdata   = MARK_FREE;
    ram_raddr   = cnt_q[IdxW-1:0];

    // Walk states read one block ahead of the one being judged.
    if (state_q == ST_ASCAN || state_q == ST_FWALK) begin
      if (issue) begin
        pend_d = 1'b1;
        eidx_d = cnt_q[IdxW-1:0];
        cnt_d  = cnt_q + CntW'(1);
      end else begin
        pend_d = 1'b0;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        ram_wdata = MARK_FREE;
        wptr_d    = wptr_q + IdxW'(1);
        if (wptr_q == IdxW'(MaxBlocks - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_d  = req_i.request_blocks;
          ok_d   = 1'b0;
          head_d = '0;
          pend_d = 1'b0;
          run_d  = '0;
          if (req_i.func == FuncAlloc) begin
            // A zero or oversized request fails without a search.
            if (req_i.request_blocks == '0 || need > {1'b0, lim}) begin
              state_d = ST_RESP;
            end else begin
              cnt_d   = '0;
              state_d = ST_ASCAN;
            end
          end else begin
            if ({1'b0, req_i.release_index} >= lim) begin
              state_d = ST_RESP;
            end else begin
              cnt_d   = {1'b0, req_i.release_index};
              first_d = 1'b1;
              state_d = ST_FWALK;
            end
          end
        end
      end

      ST_ASCAN: begin
        if (pend_q) begin
          if (ram_rdata == MARK_FREE) begin
            run_d = run_inc;
            if (run_inc == req_q) begin
              head_d  = eidx_q - req_q[IdxW-1:0] + IdxW'(1);
              end_d   = eidx_q;
              wptr_d  = eidx_q - req_q[IdxW-1:0] + IdxW'(1);
              state_d = ST_AMARK;
            end
          end else begin
            run_d = '0;
          end
        end else if (!issue) begin
          // Whole map below the limit seen without a fit.
          ok_d    = 1'b0;
          head_d  = '0;
          state_d = ST_RESP;
        end
      end

      ST_AMARK: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        ram_wdata = (wptr_q == head_q) ? MARK_HEAD : MARK_USED;
        wptr_d    = wptr_q + IdxW'(1);
        if (wptr_q == end_q) begin
          used_d  = used_q + req_q;
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_FWALK: begin
        if (pend_q) begin
          if (ram_rdata == (first_q ? MARK_HEAD : MARK_USED)) begin
            ram_we    = 1'b1;
            ram_waddr = eidx_q;
            ram_wdata = MARK_FREE;
            first_d   = 1'b0;
            if (used_q != '0) begin
              used_d = used_q - CntW'(1);
            end
          end else begin
            // A missing head fails; any other mark ends the run.
            ok_d    = !first_q;
            head_d  = '0;
            state_d = ST_RESP;
          end
        end else if (!first_q) begin
          ok_d    = 1'b1;
          head_d  = '0;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        out_valid_d       = 1'b1;
        res_d.ok          = ok_q;
        res_d.block_index = head_q;
        res_d.used_blocks = used_q;
        res_d.free_blocks = (lim > used_q) ? (lim - used_q) : '0;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      num_blocks_q <= CntW'(1024);
      used_q       <= '0;
      cnt_q        <= '0;
      run_q        <= '0;
      wptr_q       <= '0;
      pend_q       <= 1'b0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      num_blocks_q <= num_blocks_d;
      used_q       <= used_d;
      cnt_q        <= cnt_d;
      run_q        <= run_d;
      wptr_q       <= wptr_d;
      pend_q       <= pend_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    eidx_q <= eidx_d;
    head_q <= head_d;
    end_q  <= end_d;
    ok_q   <= ok_d;
    res_q  <= res_d;
  end

`ifndef SYNTH
  // A result beat is shown only once the sequencer is back to idle.
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // A failed command reports block index zero.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.ok) |-> (result_o.block_index == '0))
    else $error("failed command with nonzero block index");

  // The map is only written while a command or the clear pass runs.
  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("map write while idle");

  // The used count never exceeds the map size.
  a_used_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MaxBlocks))
    else $error("used count beyond map size");
`endif

endmodule
